### hdl/tlk_pkg.sv
// ----------------------------------------------------------------------------
// tlk_pkg
// Shared constants, types and the cosine polynomial for the tendon kinematics.
// ----------------------------------------------------------------------------
package tlk_pkg;

  localparam int AngW = 16;
  localparam int CosW = 16;   // Q1.14 cosine, range -16384..16384
  localparam int CoefW = 33;  // Q28 biased coefficient
  localparam int TermW = 33;  // radius * bend
  localparam int ProdW = 66;
  localparam int AccW = 68;

  localparam int CosLat = 7;
  localparam int AccLat = 4;
  localparam int PipeDepth = CosLat + AccLat;

  localparam logic signed [17:0] PiQ13 = 18'sd25736;
  localparam logic signed [17:0] HalfPiQ13 = 18'sd12868;
  localparam logic signed [17:0] ThirdPiQ13 = 18'sd8579;
  localparam logic signed [17:0] TwoPiQ13 = 18'sd51472;

  localparam logic [1:0] RegRadius0 = 2'd0;
  localparam logic [1:0] RegRadius1 = 2'd1;
  localparam logic [1:0] RegRadius2 = 2'd2;
  localparam logic [1:0] RegBias = 2'd3;

  localparam logic signed [31:0] PolyC4 = 32'sd26630;
  localparam logic signed [31:0] PolyC3 = 32'sd1491308;
  localparam logic signed [31:0] PolyC2 = 32'sd44739243;
  localparam logic signed [31:0] PolyC1 = 32'sd536870912;
  localparam logic signed [31:0] PolyC0 = 32'sd1073741824;

  typedef struct packed {
    logic [15:0] radius0;
    logic [15:0] radius1;
    logic [15:0] radius2;
    logic signed [15:0] bias;
  } cfg_t;

  // One Horner step: c - floor(x2 * t / 2^30); x2 < 2^32, |t| < 2^31.
  function automatic logic signed [31:0] horner_step(input logic [31:0] x2,
                                                     input logic signed [31:0] t,
                                                     input logic signed [31:0] c);
    logic signed [64:0] p;
    begin
      p = $signed({1'b0, x2}) * t;
      horner_step = c - 32'(p >>> 30);
    end
  endfunction

endpackage

### hdl/tlk_cos.sv
// ----------------------------------------------------------------------------
// tlk_cos
// Pipelined Q1.14 cosine: fold, square, four Horner steps, round.
// Advances when en is high.
// ----------------------------------------------------------------------------
module tlk_cos (
  input  logic clk,
  input  logic en,
  input  logic signed [17:0] angle,
  output logic signed [tlk_pkg::CosW-1:0] cos_out
);

  logic [13:0] m0;
  logic neg0, neg1, neg2, neg3, neg4, neg5;
  logic [31:0] x2_1, x2_2, x2_3, x2_4;
  logic signed [31:0] t2, t3, t4, t5;
  logic signed [17:0] a_w, a_abs;
  logic [17:0] m_w;
  logic signed [31:0] r_w;

  always_comb begin
    a_w = angle;
    if (a_w > tlk_pkg::PiQ13) a_w = a_w - tlk_pkg::TwoPiQ13;
    if (a_w < -tlk_pkg::PiQ13) a_w = a_w + tlk_pkg::TwoPiQ13;
    a_abs = (a_w < 0) ? -a_w : a_w;
    m_w = a_abs;
    if (a_abs > tlk_pkg::HalfPiQ13) m_w = 18'(tlk_pkg::PiQ13 - a_abs);
    r_w = (t5 + 32'sd32768) >>> 16;
    if (r_w > 32'sd16384) r_w = 32'sd16384;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0 <= m_w[13:0];
      neg0 <= a_abs > tlk_pkg::HalfPiQ13;
      x2_1 <= {28'(m0) * 28'(m0), 4'b0};
      neg1 <= neg0;
      x2_2 <= x2_1;
      t2 <= tlk_pkg::horner_step(x2_1, tlk_pkg::PolyC4, tlk_pkg::PolyC3);
      neg2 <= neg1;
      x2_3 <= x2_2;
      t3 <= tlk_pkg::horner_step(x2_2, t2, tlk_pkg::PolyC2);
      neg3 <= neg2;
      x2_4 <= x2_3;
      t4 <= tlk_pkg::horner_step(x2_3, t3, tlk_pkg::PolyC1);
      neg4 <= neg3;
      t5 <= tlk_pkg::horner_step(x2_4, t4, tlk_pkg::PolyC0);
      neg5 <= neg4;
      cos_out <= neg5 ? -r_w[15:0] : r_w[15:0];
    end
  end

endmodule

### hdl/tlk_accum.sv
// ----------------------------------------------------------------------------
// tlk_accum
// Coefficient bias, section products, running sums and Q16.16 saturation.
// Advances when en is high.
// ----------------------------------------------------------------------------
module tlk_accum (
  input  logic clk,
  input  logic en,
  input  logic signed [tlk_pkg::CosW-1:0] cos_v,
  input  logic negate,
  input  logic signed [15:0] bias,
  input  logic signed [tlk_pkg::TermW-1:0] term0,
  input  logic signed [tlk_pkg::TermW-1:0] term1,
  input  logic signed [tlk_pkg::TermW-1:0] term2,
  output logic [31:0] out0,
  output logic [31:0] out1,
  output logic [31:0] out2
);

  logic signed [tlk_pkg::CoefW-1:0] k;
  logic signed [tlk_pkg::TermW-1:0] tm0, tm1, tm2;
  logic signed [tlk_pkg::ProdW-1:0] p0, p1, p2;
  logic signed [tlk_pkg::AccW-1:0] s1, s2, s3;
  logic signed [tlk_pkg::CoefW-1:0] base_w, mag_w;

  function automatic logic [31:0] to_q16(input logic signed [tlk_pkg::AccW-1:0] a);
    logic signed [tlk_pkg::AccW-1:0] r;
    begin
      r = (a + (tlk_pkg::AccW'(1) <<< 32)) >>> 33;
      if (r > tlk_pkg::AccW'(32'sh7FFFFFFF)) to_q16 = 32'h7FFFFFFF;
      else if (r < -(tlk_pkg::AccW'(1) <<< 31)) to_q16 = 32'h80000000;
      else to_q16 = r[31:0];
    end
  endfunction

  always_comb begin
    base_w = tlk_pkg::CoefW'(cos_v) <<< 14;
    mag_w = (cos_v < 0) ? -tlk_pkg::CoefW'(cos_v) : tlk_pkg::CoefW'(cos_v);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k <= (negate ? -base_w : base_w) + tlk_pkg::CoefW'(bias) * mag_w;
      tm0 <= term0;
      tm1 <= term1;
      tm2 <= term2;
      p0 <= tlk_pkg::ProdW'(k) * tlk_pkg::ProdW'(tm0);
      p1 <= tlk_pkg::ProdW'(k) * tlk_pkg::ProdW'(tm1);
      p2 <= tlk_pkg::ProdW'(k) * tlk_pkg::ProdW'(tm2);
      s1 <= tlk_pkg::AccW'(p0);
      s2 <= tlk_pkg::AccW'(p0) + tlk_pkg::AccW'(p1);
      s3 <= tlk_pkg::AccW'(p0) + tlk_pkg::AccW'(p1) + tlk_pkg::AccW'(p2);
      out0 <= to_q16(s1);
      out1 <= to_q16(s2);
      out2 <= to_q16(s3);
    end
  end

endmodule

### hdl/tendon_length_kinematics.sv
// ----------------------------------------------------------------------------
// tendon_length_kinematics
// Three-section continuum robot tendon length changes from bend set-points.
// ----------------------------------------------------------------------------
// Input items on s_axis (phi and three section bend angles, Q3.13) produce
// one output item on m_axis with nine Q16.16 tendon length changes.
// Configuration: cfg_we/cfg_index/cfg_data write radii and compression bias.
// The user must write only while the block is idle; it is not enforced.
// From acceptance to output valid, an item passes the seven-stage cosine
// pipeline followed by the four-stage bias/multiply/sum pipeline.
// Throughput: one item per cycle. The whole pipeline advances when its
// output stage is empty or taken; a stall on m_axis freezes every stage,
// holding all items in place, and s_axis_tready drops.
// Reset clears all valid bits and the configuration registers to zero.
// ----------------------------------------------------------------------------
module tendon_length_kinematics (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // bend_direction, bend_section_0, bend_section_1, bend_section_2
  input  logic [63:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // delta_s1_a, s1_b, s1_c, s2_a, s2_b, s2_c, s3_a, s3_b, s3_c
  output logic [287:0] m_axis_tdata
);

  tlk_pkg::cfg_t cfg;
  logic [tlk_pkg::PipeDepth-1:0] vld;
  logic en;
  logic signed [15:0] phi;
  logic signed [17:0] ang_a, ang_b, ang_c;
  logic signed [15:0] cos_a, cos_b, cos_c;
  logic signed [tlk_pkg::TermW-1:0] term [3][tlk_pkg::CosLat];
  logic signed [tlk_pkg::TermW-1:0] term_w [3];
  logic [31:0] res [9];

  assign en = !vld[tlk_pkg::PipeDepth-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[tlk_pkg::PipeDepth-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tlk_pkg::RegRadius0: cfg.radius0 <= cfg_data;
        tlk_pkg::RegRadius1: cfg.radius1 <= cfg_data;
        tlk_pkg::RegRadius2: cfg.radius2 <= cfg_data;
        tlk_pkg::RegBias: cfg.bias <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[tlk_pkg::PipeDepth-2:0], s_axis_tvalid};
    end
  end

  always_comb begin
    phi = s_axis_tdata[15:0];
    ang_a = 18'(phi) + tlk_pkg::ThirdPiQ13;
    ang_b = tlk_pkg::ThirdPiQ13 - 18'(phi);
    ang_c = 18'(phi);
    term_w[0] = $signed({1'b0, cfg.radius0}) * $signed(s_axis_tdata[31:16]);
    term_w[1] = $signed({1'b0, cfg.radius1}) * $signed(s_axis_tdata[47:32]);
    term_w[2] = $signed({1'b0, cfg.radius2}) * $signed(s_axis_tdata[63:48]);
  end

  // Carry section terms alongside the cosine pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < 3; s++) begin
        term[s][0] <= term_w[s];
        for (int d = 1; d < tlk_pkg::CosLat; d++) term[s][d] <= term[s][d-1];
      end
    end
  end

  tlk_cos u_cos_a (.clk, .en, .angle(ang_a), .cos_out(cos_a));
  tlk_cos u_cos_b (.clk, .en, .angle(ang_b), .cos_out(cos_b));
  tlk_cos u_cos_c (.clk, .en, .angle(ang_c), .cos_out(cos_c));

  tlk_accum u_acc_a (.clk, .en, .cos_v(cos_a), .negate(1'b0), .bias(cfg.bias),
    .term0(term[0][tlk_pkg::CosLat-1]), .term1(term[1][tlk_pkg::CosLat-1]),
    .term2(term[2][tlk_pkg::CosLat-1]),
    .out0(res[0]), .out1(res[3]), .out2(res[6]));
  tlk_accum u_acc_b (.clk, .en, .cos_v(cos_b), .negate(1'b0), .bias(cfg.bias),
    .term0(term[0][tlk_pkg::CosLat-1]), .term1(term[1][tlk_pkg::CosLat-1]),
    .term2(term[2][tlk_pkg::CosLat-1]),
    .out0(res[1]), .out1(res[4]), .out2(res[7]));
  tlk_accum u_acc_c (.clk, .en, .cos_v(cos_c), .negate(1'b1), .bias(cfg.bias),
    .term0(term[0][tlk_pkg::CosLat-1]), .term1(term[1][tlk_pkg::CosLat-1]),
    .term2(term[2][tlk_pkg::CosLat-1]),
    .out0(res[2]), .out1(res[5]), .out2(res[8]));

  always_comb begin
    for (int i = 0; i < 9; i++) m_axis_tdata[i*32 +: 32] = res[i];
  end

  ap_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  ap_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("stalled with empty output");
  ap_flow: assert property (@(posedge clk) disable iff (rst)
    en && vld[tlk_pkg::PipeDepth-2] |=> m_axis_tvalid)
    else $error("item lost at output stage");

endmodule

### bench/tb_tendon_length_kinematics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tendon_length_kinematics
// Self-checking bench for the three-section tendon length kinematics block.
// ----------------------------------------------------------------------------
// Drives bend set-points through the input stream with random gaps, predicts
// the nine Q16.16 tendon length changes per item in a bit-exact model, and
// checks every output item in order under random output stalls. Radii and
// bias are swept between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_tendon_length_kinematics;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [287:0] m_axis_tdata;

  tendon_length_kinematics dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  localparam int Latency = 11;

  logic [15:0] radius_mirror [3];
  logic signed [15:0] bias_mirror;
  logic [287:0] expected_lengths [$];
  int mismatches;
  int items_sent;
  int lengths_checked;
  bit no_stall;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic int cos_q14(int angle);
    int a;
    int m;
    bit folded;
    longint x2;
    longint t;
    longint coef [4];
    a = angle;
    coef[0] = tlk_pkg::PolyC3;
    coef[1] = tlk_pkg::PolyC2;
    coef[2] = tlk_pkg::PolyC1;
    coef[3] = tlk_pkg::PolyC0;
    folded = 1'b0;
    if (a > tlk_pkg::PiQ13) a -= tlk_pkg::TwoPiQ13;
    if (a < -tlk_pkg::PiQ13) a += tlk_pkg::TwoPiQ13;
    m = (a < 0) ? -a : a;
    if (m > tlk_pkg::HalfPiQ13) begin
      m = tlk_pkg::PiQ13 - m;
      folded = 1'b1;
    end
    x2 = longint'(m) * m * 16;
    t = tlk_pkg::PolyC4;
    for (int i = 0; i < 4; i++) t = coef[i] - floor_shr(x2 * t, 30);
    t = floor_shr(t + 32768, 16);
    if (t > 16384) t = 16384;
    return folded ? -int'(t) : int'(t);
  endfunction

  function automatic longint biased_coef(int c, bit negate);
    longint mag;
    longint base;
    mag = (c < 0) ? -longint'(c) : longint'(c);
    base = longint'(c) * 16384;
    return (negate ? -base : base) + longint'(bias_mirror) * mag;
  endfunction

  function automatic logic [31:0] round_sat_q16(logic signed [127:0] acc);
    logic signed [127:0] r;
    r = (acc + (128'sd1 <<< 32)) >>> 33;
    if (r > 128'sd2147483647) return 32'h7fffffff;
    if (r < -128'sd2147483648) return 32'h80000000;
    return r[31:0];
  endfunction

  function automatic logic [287:0] tendon_lengths(logic [63:0] bends);
    int phi;
    longint k [3];
    logic signed [127:0] acc [3];
    logic signed [127:0] rt;
    logic [287:0] res;
    phi = $signed(bends[15:0]);
    k[0] = biased_coef(cos_q14(phi + tlk_pkg::ThirdPiQ13), 1'b0);
    k[1] = biased_coef(cos_q14(tlk_pkg::ThirdPiQ13 - phi), 1'b0);
    k[2] = biased_coef(cos_q14(phi), 1'b1);
    for (int j = 0; j < 3; j++) acc[j] = 0;
    for (int s = 0; s < 3; s++) begin
      rt = $signed({1'b0, radius_mirror[s]}) * $signed(bends[16*(s+1) +: 16]);
      for (int j = 0; j < 3; j++) begin
        acc[j] += 128'(signed'(k[j])) * rt;
        res[32*(s*3+j) +: 32] = round_sat_q16(acc[j]);
      end
    end
    return res;
  endfunction

  // Stall the output side at random; hold ready high during no-stall stretches.
  initial begin
    int gap;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        gap = no_stall ? 0 : $urandom_range(0, 17);
        if (gap > 0 && ($urandom_range(0, 3) != 0)) begin
          m_axis_tready <= 1'b0;
          repeat (gap - 1) @(posedge clk);
          @(posedge clk);
        end
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    logic [287:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      lengths_checked++;
      if (expected_lengths.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output item %h", m_axis_tdata);
      end else begin
        want = expected_lengths.pop_front();
        for (int f = 0; f < 9; f++) begin
          if (m_axis_tdata[32*f +: 32] !== want[32*f +: 32]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("length field %0d: expected %h, got %h", f,
                       want[32*f +: 32], m_axis_tdata[32*f +: 32]);
          end
        end
      end
    end
  end

  // Valid stays high into a back-to-back item; drop it only before a gap.
  task automatic send_bends(logic [63:0] bends);
    int gap;
    gap = no_stall ? 0 : $urandom_range(0, 17);
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= bends;
    do @(posedge clk); while (!s_axis_tready);
    expected_lengths.push_back(tendon_lengths(bends));
    items_sent++;
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (expected_lengths.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    if (idx == tlk_pkg::RegBias) bias_mirror = value;
    else radius_mirror[idx] = value;
  endtask

  task automatic set_config(logic [15:0] r0, logic [15:0] r1, logic [15:0] r2,
                            logic [15:0] b);
    drain();
    write_reg(tlk_pkg::RegRadius0, r0);
    write_reg(tlk_pkg::RegRadius1, r1);
    write_reg(tlk_pkg::RegRadius2, r2);
    write_reg(tlk_pkg::RegBias, b);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] random_angle();
    case ($urandom_range(0, 5))
      0: return 16'h8000 | 16'($urandom_range(0, 3));
      1: return 16'h7fff - 16'($urandom_range(0, 3));
      2: return 16'($urandom_range(0, 25736 * 2)) - 16'd25736;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [63:0] random_bends();
    return {random_angle(), random_angle(), random_angle(), random_angle()};
  endfunction

  task automatic test_directed_angles();
    logic [15:0] phis [12];
    phis = '{16'h0000, 16'h8000, 16'h7fff, 16'd25736, -16'sd25736, 16'd12868,
             -16'sd12868, 16'd8579, -16'sd8579, 16'd25737, 16'd34315, 16'hffff};
    set_config(16'h0100, 16'h0200, 16'h0080, 16'h0000);
    foreach (phis[i]) send_bends({16'h1000, 16'hf000, 16'h2000, phis[i]});
    set_config(16'hffff, 16'hffff, 16'hffff, 16'h8000);
    send_bends({16'h7fff, 16'h7fff, 16'h7fff, 16'h0000});
    send_bends({16'h8000, 16'h8000, 16'h8000, 16'h8000});
    send_bends({16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
    set_config(16'hffff, 16'hffff, 16'hffff, 16'h7fff);
    send_bends({16'h7fff, 16'h7fff, 16'h7fff, 16'd8579});
    send_bends({16'h8000, 16'h8000, 16'h8000, 16'd25736});
    send_bends({16'h0000, 16'h0000, 16'h0000, 16'h1234});
  endtask

  task automatic test_zero_config();
    set_config(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    repeat (5) send_bends(random_bends());
  endtask

  task automatic test_random_phase(int n);
    set_config(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
    no_stall = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < n; i++) begin
      send_bends(random_bends());
      // Hold the sender at most once, at random, until the pipeline is empty.
      if (i == n / 2 && $urandom_range(0, 1) == 0) begin
        s_axis_tvalid <= 1'b0;
        while (expected_lengths.size() != 0) @(posedge clk);
      end
    end
    no_stall = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = tlk_pkg::RegRadius0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    no_stall = 1'b0;
    mismatches = 0;
    items_sent = 0;
    lengths_checked = 0;
    foreach (radius_mirror[i]) radius_mirror[i] = '0;
    bias_mirror = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_zero_config();
    test_directed_angles();
    for (int p = 0; p < 16; p++) test_random_phase(84);
    drain();
    $display("covered %0d set-points, %0d output items checked, 20 register settings",
             items_sent, lengths_checked);
    if (mismatches == 0 && expected_lengths.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d items left", mismatches, expected_lengths.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
